// File: rtl/core/rsag_pkg.sv
// ----------------------------------------------------------------------------
// rsag_pkg: shared types and constants of the spherical angle generator
// Beat types, CORDIC arctangent table and fixed-point angle constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rsag_pkg;

    // sweep count limits and the register's reset value
    localparam int unsigned MAX_DIVISIONS = 64;
    localparam logic [6:0]  DIV_RESET     = 7'd8;

    // angle format: radians with 13 fraction bits, CORDIC runs at 2^30
    localparam int unsigned ANGLE_FRAC_BITS = 13;
    localparam int unsigned ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

    // pipeline depths
    localparam int unsigned N_SQRT    = 29;   // one result bit per cell
    localparam int unsigned N_CORDIC  = 32;   // one rotation per cell
    localparam int unsigned N_STAGES  = N_SQRT + N_CORDIC + 2;
    localparam int unsigned DIV_STEPS = 15;   // quotient bits of the sweep

    // pi and pi/2 at scale 2^30, pi at output scale
    localparam logic signed [33:0] PI30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI30 = 34'sd1686629713;
    localparam logic [31:0]        PI30_U    = 32'd3373259426;
    localparam logic [14:0]        PI_OUT    = 15'd25736;

    // atan(2^-k) at scale 2^30, truncated
    localparam logic [29:0] ATAN_TAB [N_CORDIC] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
        30'h00000001, 30'h00000000
    };

    // input beat
    typedef struct packed {
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
    } t_coord;

    // output beat
    typedef struct packed {
        logic signed [15:0] sweep_angle;
        logic [14:0]        polar_angle;
        logic signed [15:0] azimuth_angle;
        logic               last_of_run;
    } t_res;

    // finished angles of one point
    typedef struct packed {
        logic [14:0]        polar_angle;
        logic signed [15:0] azimuth_angle;
    } t_point;

    // square root lane: radicand bits left, remainder, partial root, cosine term
    typedef struct packed {
        logic [29:0]        rad;
        logic [30:0]        rem;
        logic [28:0]        root;
        logic signed [31:0] aux;
    } t_sqrt_lane;

    // CORDIC vectoring lane
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] ang;
    } t_cordic_lane;

    // azimuth special cases carried beside the lanes
    typedef struct packed {
        logic pole;
        logic beyond;
        logic xneg;
        logic yneg;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/core/rotation_sample_angle_gen.sv
// ----------------------------------------------------------------------------
// rotation_sample_angle_gen: unit vector to polar/azimuth angles with sweep
// Input beats carry a point (x, y, z) in Q1.14; output beats carry
// (sweep, polar, azimuth, last) in Q2.13 radians.
//
// Usage:
//  - Input channel: i_valid / o_stall with i_coord. A beat is taken at a
//    clock edge with i_valid high and o_stall low.
//  - Output channel: o_valid / i_stall with o_res. Each point yields n beats,
//    n = sweep divisions (0 acts as 1, above 64 as 64); last_of_run marks the
//    final one. Runs of consecutive points follow without gaps.
//  - Configuration: i_cfg_we writes i_cfg_data into the division count; write
//    only while the block is empty.
//  - Throughput: one output beat per cycle while i_stall is low; the input
//    stalls once the run sequencer falls behind. The angle chain (29
//    square-root cells, 32 CORDIC cells) takes a point per cycle unless stalled.
//  - Reset clears all valid bits; the division count returns to 8.
//  - While i_stall holds the output beat, the sweep pipeline freezes, and the
//    angle chain freezes as soon as its finished point cannot be handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_sample_angle_gen (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [6:0]        i_cfg_data,
    input  wire              i_valid,
    output logic             o_stall,
    input  rsag_pkg::t_coord i_coord,
    output logic             o_valid,
    input  wire              i_stall,
    output rsag_pkg::t_res   o_res
);
    import rsag_pkg::*;

    logic [6:0]          r_div;
    logic                chain_en;
    logic                in_acc;
    logic                pt_take;

    logic signed [15:0]  z_c;
    logic signed [31:0]  zz;
    logic signed [31:0]  xs;
    logic signed [31:0]  xx;
    logic signed [31:0]  r2_w;
    logic [28:0]         r2;
    logic                beyond;
    t_sqrt_lane          n_pre_pol;
    t_sqrt_lane          n_pre_az;
    t_flags              n_flg;

    t_sqrt_lane          r_pre_pol;
    t_sqrt_lane          r_pre_az;
    t_sqrt_lane          sq_pol [N_SQRT+1];
    t_sqrt_lane          sq_az  [N_SQRT+1];
    t_cordic_lane        r_rot_pol;
    t_cordic_lane        r_rot_az;
    t_cordic_lane        cd_pol [N_CORDIC+1];
    t_cordic_lane        cd_az  [N_CORDIC+1];

    logic [N_STAGES-1:0] r_vld;
    t_flags              r_flg  [N_STAGES];

    logic [14:0]         pol_q;
    logic [14:0]         az_q;
    logic [14:0]         az_base;
    logic signed [15:0]  az_s;
    t_point              r_f;
    logic                r_f_valid;

    // division count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIV_RESET;
        end else if (i_cfg_we) begin
            r_div <= i_cfg_data;
        end
    end

    // chain advances unless its finished point waits for the sequencer
    assign chain_en = !r_f_valid || pt_take;
    assign in_acc   = i_valid && chain_en;
    assign o_stall  = !chain_en;

    // clamp z, sin^2 of polar, azimuth radicand and special cases
    always_comb begin
        priority if (i_coord.coord_z > 16'sd16384) begin
            z_c = 16'sd16384;
        end else if (i_coord.coord_z < -16'sd16384) begin
            z_c = -16'sd16384;
        end else begin
            z_c = i_coord.coord_z;
        end
        zz     = 32'(z_c) * 32'(z_c);
        r2_w   = 32'sd268435456 - zz;
        r2     = r2_w[28:0];
        xs     = 32'(i_coord.coord_x);
        xx     = xs * xs;
        beyond = (xx >= $signed({3'b000, r2}));

        n_pre_pol.rad  = {1'b0, r2};
        n_pre_pol.rem  = '0;
        n_pre_pol.root = '0;
        n_pre_pol.aux  = 32'(z_c) * 32'sd16384;

        n_pre_az.rad   = beyond ? 30'd0 : {1'b0, 29'(r2 - xx[28:0])};
        n_pre_az.rem   = '0;
        n_pre_az.root  = '0;
        n_pre_az.aux   = -(xs * 32'sd16384);

        n_flg.pole     = (r2 == 29'd0);
        n_flg.beyond   = beyond;
        n_flg.xneg     = i_coord.coord_x[15];
        n_flg.yneg     = i_coord.coord_y[15];
    end

    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_pre_pol <= n_pre_pol;
            r_pre_az  <= n_pre_az;
        end
    end

    // square root cells
    assign sq_pol[0] = r_pre_pol;
    assign sq_az[0]  = r_pre_az;

    genvar g;
    for (g = 0; g < N_SQRT; g++) begin : g_sq
        rsag_sqrt_cell u_pol (
            .i_clk  (i_clk),
            .i_en   (chain_en),
            .i_lane (sq_pol[g]),
            .o_lane (sq_pol[g+1])
        );
        rsag_sqrt_cell u_az (
            .i_clk  (i_clk),
            .i_en   (chain_en),
            .i_lane (sq_az[g]),
            .o_lane (sq_az[g+1])
        );
    end

    // quarter turn when the cosine term is negative
    function automatic t_cordic_lane prerot(input t_sqrt_lane l);
        t_cordic_lane       c;
        logic signed [31:0] v;
        v = $signed({3'b000, l.root});
        if (l.aux[31]) begin
            c.x   = v;
            c.y   = -l.aux;
            c.ang = HALF_PI30;
        end else begin
            c.x   = l.aux;
            c.y   = v;
            c.ang = '0;
        end
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_rot_pol <= prerot(sq_pol[N_SQRT]);
            r_rot_az  <= prerot(sq_az[N_SQRT]);
        end
    end

    // CORDIC cells
    assign cd_pol[0] = r_rot_pol;
    assign cd_az[0]  = r_rot_az;

    for (g = 0; g < N_CORDIC; g++) begin : g_cd
        rsag_cordic_cell u_pol (
            .i_clk  (i_clk),
            .i_en   (chain_en),
            .i_step (5'(g)),
            .i_lane (cd_pol[g]),
            .o_lane (cd_pol[g+1])
        );
        rsag_cordic_cell u_az (
            .i_clk  (i_clk),
            .i_en   (chain_en),
            .i_step (5'(g)),
            .i_lane (cd_az[g]),
            .o_lane (cd_az[g+1])
        );
    end

    // valid bits and flags beside the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (chain_en) begin
            r_vld <= {r_vld[N_STAGES-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_flg[0] <= n_flg;
            for (int p = 1; p < N_STAGES; p++) begin
                r_flg[p] <= r_flg[p-1];
            end
        end
    end

    // clamp to [0, pi] and round to output scale
    function automatic logic [14:0] to_out(input logic signed [33:0] a);
        logic signed [33:0] c;
        logic [33:0]        s;
        priority if (a < 34'sd0) begin
            c = '0;
        end else if (a > PI30) begin
            c = PI30;
        end else begin
            c = a;
        end
        s = $unsigned(c) + (34'd1 << (ANG_SHIFT - 1));
        return s[ANG_SHIFT+14:ANG_SHIFT];
    endfunction

    // azimuth special cases and sign
    always_comb begin
        pol_q = to_out(cd_pol[N_CORDIC].ang);
        az_q  = to_out(cd_az[N_CORDIC].ang);
        priority if (r_flg[N_STAGES-1].pole) begin
            az_base = '0;
        end else if (r_flg[N_STAGES-1].beyond) begin
            az_base = r_flg[N_STAGES-1].xneg ? 15'd0 : PI_OUT;
        end else begin
            az_base = az_q;
        end
        if (r_flg[N_STAGES-1].yneg && !r_flg[N_STAGES-1].pole && az_base != PI_OUT) begin
            az_s = -$signed({1'b0, az_base});
        end else begin
            az_s = $signed({1'b0, az_base});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (chain_en) begin
            r_f_valid <= r_vld[N_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_f.polar_angle   <= pol_q;
            r_f.azimuth_angle <= az_s;
        end
    end

    // run sequencer and sweep pipeline
    rsag_sweep u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_divisions (r_div),
        .i_pt_valid  (r_f_valid),
        .i_pt        (r_f),
        .o_pt_take   (pt_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/core/rsag_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsag_sqrt_cell: one digit of a restoring square root
// Brings down two radicand bits, settles one root bit, registers the lane.
// ----------------------------------------------------------------------------
`default_nettype none

module rsag_sqrt_cell (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  rsag_pkg::t_sqrt_lane i_lane,
    output rsag_pkg::t_sqrt_lane o_lane
);
    import rsag_pkg::*;

    t_sqrt_lane  r_lane;
    t_sqrt_lane  n_lane;
    logic [32:0] rem2;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // trial subtract of 4*root+1
    always_comb begin
        rem2        = {i_lane.rem, i_lane.rad[29:28]};
        trial       = {2'b00, i_lane.root, 2'b01};
        diff        = rem2 - trial;
        ge          = (rem2 >= trial);
        n_lane.rad  = {i_lane.rad[27:0], 2'b00};
        n_lane.rem  = ge ? diff[30:0] : rem2[30:0];
        n_lane.root = {i_lane.root[27:0], ge};
        n_lane.aux  = i_lane.aux;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// File: rtl/core/rsag_cordic_cell.sv
// ----------------------------------------------------------------------------
// rsag_cordic_cell: one CORDIC vectoring rotation
// Turns the vector toward the x axis by atan(2^-k) and registers the lane.
// ----------------------------------------------------------------------------
`default_nettype none

module rsag_cordic_cell (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire [4:0]              i_step,
    input  rsag_pkg::t_cordic_lane i_lane,
    output rsag_pkg::t_cordic_lane o_lane
);
    import rsag_pkg::*;

    t_cordic_lane       r_lane;
    t_cordic_lane       n_lane;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [33:0] da;

    // floor shifts, direction from the sign of y
    always_comb begin
        sx = i_lane.x >>> i_step;
        sy = i_lane.y >>> i_step;
        da = $signed({4'b0000, ATAN_TAB[i_step]});
        if (!i_lane.y[31]) begin
            n_lane.x   = i_lane.x + sy;
            n_lane.y   = i_lane.y - sx;
            n_lane.ang = i_lane.ang + da;
        end else begin
            n_lane.x   = i_lane.x - sy;
            n_lane.y   = i_lane.y + sx;
            n_lane.ang = i_lane.ang - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// File: rtl/core/rsag_sweep.sv
// ----------------------------------------------------------------------------
// rsag_sweep: run sequencer and sweep angle pipeline
// Issues n beats per point and works out -pi + i*2pi/n with a pipelined
// restoring divide by n, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsag_sweep (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [6:0]        i_divisions,
    input  wire              i_pt_valid,
    input  rsag_pkg::t_point i_pt,
    output logic             o_pt_take,
    output logic             o_valid,
    input  wire              i_stall,
    output rsag_pkg::t_res   o_res
);
    import rsag_pkg::*;

    typedef struct packed {
        logic [6:0]  rem;
        logic [14:0] dl;
        logic [14:0] q;
        logic [6:0]  n;
        logic        neg;
        t_point      pt;
        logic        last;
    } t_div;

    logic               en;
    logic [6:0]         n_clamp;
    logic               last_issue;

    logic               r_busy;
    logic [5:0]         r_idx;
    logic [6:0]         r_n;
    t_point             r_pt;

    logic signed [7:0]  num;
    logic [6:0]         mag;
    logic [38:0]        prod;
    t_div               n_s1;

    t_div               r_dv   [DIV_STEPS+1];
    logic [DIV_STEPS:0] r_dvld;
    t_div               n_dv   [DIV_STEPS];

    logic               r_o_valid;
    t_res               r_res;
    logic signed [15:0] q_s;

    // whole pipeline moves unless the output beat is held
    assign en = !(r_o_valid && i_stall);

    // division count: zero acts as one, large values saturate
    always_comb begin
        priority if (i_divisions == 7'd0) begin
            n_clamp = 7'd1;
        end else if (i_divisions > 7'(MAX_DIVISIONS)) begin
            n_clamp = 7'(MAX_DIVISIONS);
        end else begin
            n_clamp = i_divisions;
        end
    end

    assign last_issue = r_busy && ({1'b0, r_idx} == (r_n - 7'd1));
    assign o_pt_take  = en && i_pt_valid && (!r_busy || last_issue);

    // run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (en) begin
            if (o_pt_take) begin
                r_busy <= 1'b1;
            end else if (last_issue) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pt_take) begin
                r_idx <= 6'd0;
                r_n   <= n_clamp;
                r_pt  <= i_pt;
            end else if (r_busy) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    // dividend: floor((|2i-n|*pi + n*2^16) / 2^17), later divided by n
    always_comb begin
        num        = $signed({1'b0, r_idx, 1'b0}) - $signed({1'b0, r_n});
        mag        = num[7] ? 7'(-num) : num[6:0];
        prod       = 39'(mag) * 39'(PI30_U) + (39'(r_n) << 16);
        n_s1.rem   = {1'b0, prod[37:32]};
        n_s1.dl    = prod[31:17];
        n_s1.q     = 15'd0;
        n_s1.n     = r_n;
        n_s1.neg   = num[7];
        n_s1.pt    = r_pt;
        n_s1.last  = last_issue;
    end

    // restoring divide steps
    genvar g;
    for (g = 0; g < DIV_STEPS; g++) begin : g_div
        logic [7:0] rem2;
        logic [7:0] dn;
        logic       ge;
        always_comb begin
            rem2          = {r_dv[g].rem, r_dv[g].dl[14]};
            dn            = {1'b0, r_dv[g].n};
            ge            = (rem2 >= dn);
            n_dv[g]       = r_dv[g];
            n_dv[g].rem   = ge ? 7'(rem2 - dn) : rem2[6:0];
            n_dv[g].dl    = {r_dv[g].dl[13:0], 1'b0};
            n_dv[g].q     = {r_dv[g].q[13:0], ge};
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[g+1] <= n_dv[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else if (en) begin
            r_dvld <= {r_dvld[DIV_STEPS-1:0], r_busy};
        end
    end

    // sign and output register
    assign q_s = r_dv[DIV_STEPS].neg ? -$signed({1'b0, r_dv[DIV_STEPS].q})
                                     :  $signed({1'b0, r_dv[DIV_STEPS].q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_dvld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res.sweep_angle   <= q_s;
            r_res.polar_angle   <= r_dv[DIV_STEPS].pt.polar_angle;
            r_res.azimuth_angle <= r_dv[DIV_STEPS].pt.azimuth_angle;
            r_res.last_of_run   <= r_dv[DIV_STEPS].last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: tb/rotation_sample_angle_gen_tb.sv
// ----------------------------------------------------------------------------
// rotation_sample_angle_gen_tb: self-checking bench for the angle generator
// Drives points through the valid/stall input, predicts each run of sweep
// tuples with a bit-exact integer model, and checks every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_sample_angle_gen_tb;

    import rsag_pkg::*;

    localparam longint PI_SCALED = 64'sd3373259426;
    localparam int     TAIL_CYCLES = 120;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    t_coord     i_coord;
    logic       o_valid;
    logic       i_stall;
    t_res       o_res;

    rotation_sample_angle_gen u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_coord    (i_coord),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

    // pending points and expected tuples
    t_coord     point_q[$];
    t_res       tuple_q[$];
    logic [6:0] div_reg;
    int         fail_cnt;
    bit         calm;       // no idling on either side
    bit         hold_send;
    bit         in_taken = 1'b0;   // input beat taken at the last rising edge

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor square root
    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // CORDIC atan2(v, u), v >= 0, rounded to output scale
    function automatic longint vector_angle(input longint v, input longint u);
        longint cx;
        longint cy;
        longint acc;
        longint nx;
        longint ny;
        cx = u;
        cy = v;
        acc = 0;
        if (cx < 0) begin
            cx = v;
            cy = -u;
            acc = PI_SCALED / 2;
        end
        for (int k = 0; k < N_CORDIC; k++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> k);
                ny = cy - (cx >>> k);
                acc = acc + longint'(ATAN_TAB[k]);
            end else begin
                nx = cx - (cy >>> k);
                ny = cy + (cx >>> k);
                acc = acc - longint'(ATAN_TAB[k]);
            end
            cx = nx;
            cy = ny;
        end
        if (acc < 0) acc = 0;
        if (acc > PI_SCALED) acc = PI_SCALED;
        return (acc + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    endfunction

    // expected run of tuples for one point
    task automatic predict_run(input t_coord pt);
        longint px;
        longint py;
        longint pz;
        longint r2;
        longint x2;
        longint polar;
        longint azim;
        longint pi_out;
        longint num;
        longint unsigned mag;
        longint unsigned dv;
        longint unsigned q;
        longint sweep;
        int n;
        t_res tp;
        px = pt.coord_x;
        py = pt.coord_y;
        pz = pt.coord_z;
        n = div_reg;
        if (n < 1) n = 1;
        if (n > MAX_DIVISIONS) n = MAX_DIVISIONS;
        if (pz > 16384) pz = 16384;
        if (pz < -16384) pz = -16384;
        pi_out = vector_angle(0, -1);
        r2 = (64'sd1 <<< 28) - pz * pz;
        polar = vector_angle(longint'(sqrt_floor(longint'(r2) << 28)), pz * 16384);
        if (r2 == 0) begin
            azim = 0;
        end else begin
            x2 = px * px;
            if (x2 >= r2)
                azim = (px < 0) ? 0 : pi_out;
            else
                azim = vector_angle(longint'(sqrt_floor(longint'(r2 - x2) << 28)),
                                    -px * 16384);
            if (py < 0 && azim != pi_out) azim = -azim;
        end
        for (int i = 0; i < n; i++) begin
            num = 2 * i - n;
            mag = longint'(num < 0 ? -num : num) * PI_SCALED;
            dv = longint'(n) << ANG_SHIFT;
            q = (mag + dv / 2) / dv;
            sweep = (num < 0) ? -longint'(q) : longint'(q);
            tp.sweep_angle = sweep[15:0];
            tp.polar_angle = polar[14:0];
            tp.azimuth_angle = azim[15:0];
            tp.last_of_run = (i + 1 == n);
            tuple_q.push_back(tp);
        end
    endtask

    // input driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold the beat until it is taken
        end else begin
            if (point_q.size() != 0 && !hold_send && (calm || $urandom_range(99) >= 30)) begin
                i_valid <= 1'b1;
                i_coord <= point_q[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !calm && ($urandom_range(99) < 30);
    end

    // acceptance of input beats and output checks at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            predict_run(point_q.pop_front());
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (tuple_q.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, o_res);
                fail_cnt++;
            end else begin
                t_res ex;
                ex = tuple_q.pop_front();
                if (ex.sweep_angle !== o_res.sweep_angle)
                    $display("%0t: sweep_angle expected %0d actual %0d", $time,
                             ex.sweep_angle, o_res.sweep_angle);
                if (ex.polar_angle !== o_res.polar_angle)
                    $display("%0t: polar_angle expected %0d actual %0d", $time,
                             ex.polar_angle, o_res.polar_angle);
                if (ex.azimuth_angle !== o_res.azimuth_angle)
                    $display("%0t: azimuth_angle expected %0d actual %0d", $time,
                             ex.azimuth_angle, o_res.azimuth_angle);
                if (ex.last_of_run !== o_res.last_of_run)
                    $display("%0t: last_of_run expected %0d actual %0d", $time,
                             ex.last_of_run, o_res.last_of_run);
                if (ex !== o_res) fail_cnt++;
            end
        end
    end

    // random point: mostly within the unit cube, some with z at +-1, some raw noise
    function automatic t_coord rand_point();
        t_coord pt;
        int sel;
        sel = $urandom_range(9);
        pt.coord_x = 16'($urandom);
        pt.coord_y = 16'($urandom);
        pt.coord_z = 16'($urandom);
        if (sel < 7) begin
            pt.coord_x = 16'(int'($urandom_range(32767)) - 16384);
            pt.coord_y = 16'(int'($urandom_range(32767)) - 16384);
            pt.coord_z = 16'(int'($urandom_range(32767)) - 16384);
        end else if (sel == 7) begin
            pt.coord_z = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
        end
        return pt;
    endfunction

    // wait until all tuples are out, then let the pipe drain
    task automatic drain();
        while (point_q.size() != 0 || tuple_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // write the division count while the block is empty
    task automatic set_divisions(input logic [6:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        div_reg = val;
    endtask

    // stimulus
    initial begin
        logic [6:0] div_set [6];
        div_set = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd3, 7'd17};
        fail_cnt = 0;
        calm = 1'b0;
        hold_send = 1'b0;
        div_reg = DIV_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_coord = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: poles, clamping, ratio beyond one, sign of y, extremes
        point_q.push_back('{16'sd0, 16'sd0, 16'sd16384});
        point_q.push_back('{16'sd0, 16'sd0, -16'sd16384});
        point_q.push_back('{16'sd0, 16'sd0, 16'sd32767});
        point_q.push_back('{16'sd0, 16'sd0, -16'sd32768});
        point_q.push_back('{16'sd16384, 16'sd0, 16'sd0});
        point_q.push_back('{-16'sd16384, 16'sd0, 16'sd0});
        point_q.push_back('{16'sd16384, -16'sd5, 16'sd0});
        point_q.push_back('{-16'sd16384, -16'sd5, 16'sd0});
        point_q.push_back('{16'sd32767, 16'sd32767, 16'sd100});
        point_q.push_back('{-16'sd32768, -16'sd32768, -16'sd100});
        point_q.push_back('{16'sd0, 16'sd16384, 16'sd0});
        point_q.push_back('{16'sd0, -16'sd16384, 16'sd0});
        point_q.push_back('{16'sd11585, -16'sd11585, 16'sd0});
        point_q.push_back('{-16'sd9459, 16'sd9459, 16'sd9459});
        point_q.push_back('{16'sd1, -16'sd1, 16'sd16383});
        point_q.push_back('{-16'sd21846, 16'sd10923, -16'sd16383});

        // random phases across division counts
        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) set_divisions(div_set[ph - 1]);
            calm = (ph == 2);
            for (int k = 0; k < 65; k++) begin
                point_q.push_back(rand_point());
                if (ph == 5 && k == 30) begin
                    // sender holds off until the pipe is empty
                    while (point_q.size() != 0) @(posedge i_clk);
                    hold_send = 1'b1;
                    while (tuple_q.size() != 0) @(posedge i_clk);
                    hold_send = 1'b0;
                end
            end
        end
        calm = 1'b0;
        drain();
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rsag_pkg.sv
rtl/core/rsag_sqrt_cell.sv
rtl/core/rsag_cordic_cell.sv
rtl/core/rsag_sweep.sv
rtl/core/rotation_sample_angle_gen.sv
tb/rotation_sample_angle_gen_tb.sv
